/* rtl/fip_pkg.sv */
// Shared types and constants of the Feistel identifier permutation.
package fip_pkg;

  // Round function constants.
  localparam int unsigned MUL_K        = 1366;
  localparam int unsigned ADD_K        = 150889;
  localparam int unsigned MOD_K        = 714025;
  // Rounding offset: round(n / MOD_K) equals floor((n + HALF_K) / MOD_K) for odd MOD_K.
  localparam int unsigned HALF_K       = (MOD_K - 1) / 2;
  localparam int unsigned SCALE_WIDE   = 32767;
  localparam int unsigned SCALE_NARROW = 8191;

  // Reciprocal of MOD_K scaled by 2^40, used for both quotient estimates.
  localparam int unsigned RECIP_SHIFT = 40;
  localparam logic [20:0] RECIP       = 21'((64'd1 << RECIP_SHIFT) / 64'(MOD_K));

  // Half width in each mode.
  localparam int unsigned HALF_WIDE   = 16;
  localparam int unsigned HALF_NARROW = 13;

  // One item on its way through the rounds.
  typedef struct packed {
    logic        mode;
    logic [15:0] left;
    logic [15:0] right;
  } half_pair_t;

endpackage

/* rtl/feistel_id_permutation.sv */
// Top level of the Feistel identifier permutation: rounds in a pipeline and an output register.
//
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    plain_value_i [31:0]
// out       output     out_valid_o / out_stall_i  permuted_value_o [31:0]
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_data_i (half_mode)
//
// One transaction enters per cycle while in_stall_o is low; each transaction passes the eight
// register stages of each round (two constant-reciprocal divisions per round) and then the
// output register. The mode is captured with each transaction at entry.
// Reset clears all valid bits and sets half_mode to 0.
// A stall at the output fills empty stages first, so the input keeps accepting until
// the pipeline is full.
module feistel_id_permutation #(
  parameter int unsigned ROUND_COUNT = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] plain_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] permuted_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i
);

  logic                half_mode_q;
  logic                link_valid [ROUND_COUNT+1];
  logic                link_ready [ROUND_COUNT+1];
  fip_pkg::half_pair_t link_item  [ROUND_COUNT+1];

  logic                out_valid_q;
  logic                out_mode_q;
  logic [31:0]         out_q;
  logic [31:0]         out_d;
  logic                out_en;
  fip_pkg::half_pair_t last;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      half_mode_q <= cfg_data_i;
    end
  end

  // Split the input word into halves for the selected mode.
  always_comb begin
    link_item[0].mode = half_mode_q;
    if (half_mode_q) begin
      link_item[0].left  = {3'b000, plain_value_i[25:13]};
      link_item[0].right = {3'b000, plain_value_i[12:0]};
    end else begin
      link_item[0].left  = plain_value_i[31:16];
      link_item[0].right = plain_value_i[15:0];
    end
  end

  assign link_valid[0] = in_valid_i;
  assign in_stall_o    = !link_ready[0];

  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
    fip_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_valid[g]),
      .item_i  (link_item[g]),
      .ready_o (link_ready[g]),
      .valid_o (link_valid[g+1]),
      .item_o  (link_item[g+1]),
      .ready_i (link_ready[g+1])
    );
  end

  assign last   = link_item[ROUND_COUNT];
  assign out_en = !out_valid_q || !out_stall_i;
  assign link_ready[ROUND_COUNT] = out_en;

  // Final right half goes on top, final left half below it.
  assign out_d = last.mode ? {6'b000000, last.right[12:0], last.left[12:0]}
                           : {last.right, last.left};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= link_valid[ROUND_COUNT];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_q      <= out_d;
      out_mode_q <= last.mode;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign permuted_value_o = out_q;

  a_no_stall_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("Input stalled although the output side is taking transactions.");

  a_narrow_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_mode_q) |-> (permuted_value_o[31:26] == 6'b000000))
    else $error("Narrow mode result has upper bits set.");

  a_mode_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_valid_i |=> $stable(half_mode_q))
    else $error("Mode changed without a configuration transaction.");

endmodule

/* rtl/fip_round.sv */
// One Feistel round as an eight-stage pipeline with per-stage valid bits.
module fip_round (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  fip_pkg::half_pair_t item_i,
  output logic                ready_o,
  output logic                valid_o,
  output fip_pkg::half_pair_t item_o,
  input  logic                ready_i
);

  localparam int unsigned Stages = 8;

  logic [Stages-1:0] valid_q;
  logic [Stages-1:0] en;
  logic [Stages-1:0] ready_nx;

  logic [15:0] l_q [Stages];
  logic [15:0] r_q [Stages];
  logic        mode_q [Stages];

  logic [26:0] x0_q, x1_q, x_d;
  logic [6:0]  q1_q, q1_d;
  logic [47:0] prod_a;
  logic [20:0] m0_q, m0_d;
  logic [19:0] m_q, m_d;
  logic [14:0] scale;
  logic [34:0] y4_q, y5_q, y_d;
  logic [45:0] prod_b;
  logic [14:0] qe5_q, qe6_q, qe_d;
  logic [20:0] rem_q, rem_d;
  logic [14:0] f;

  // A stage takes new data when it is empty or its successor takes its data.
  always_comb begin
    ready_nx[Stages-1] = ready_i;
    for (int k = Stages - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || ready_nx[k];
      if (k > 0) begin
        ready_nx[k-1] = en[k];
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = valid_q[Stages-1];
  assign item_o  = '{mode: mode_q[Stages-1], left: l_q[Stages-1], right: r_q[Stages-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < Stages; k++) begin
        if (en[k]) begin
          valid_q[k] <= (k == 0) ? valid_i : valid_q[k-1];
        end
      end
    end
  end

  // Stage 0: affine step on the right half.
  assign x_d = 27'(item_i.right) * 27'(fip_pkg::MUL_K) + 27'(fip_pkg::ADD_K);
  // Stage 1: quotient estimate, exact or one too small.
  assign prod_a = 48'(x0_q) * 48'(fip_pkg::RECIP);
  assign q1_d   = prod_a[46:40];
  // Stage 2: remainder before correction, below twice the modulus.
  assign m0_d = 21'(x1_q - 27'(q1_q) * 27'(fip_pkg::MOD_K));
  // Stage 3: final remainder.
  assign m_d = (m0_q >= 21'(fip_pkg::MOD_K)) ? 20'(m0_q - 21'(fip_pkg::MOD_K)) : m0_q[19:0];
  // Stage 4: scaled value with rounding offset.
  assign scale = mode_q[3] ? 15'(fip_pkg::SCALE_NARROW) : 15'(fip_pkg::SCALE_WIDE);
  assign y_d   = 35'(m_q) * 35'(scale) + 35'(fip_pkg::HALF_K);
  // Stage 5: quotient estimate from the top bits, exact or one too small.
  assign prod_b = 46'(y4_q[34:10]) * 46'(fip_pkg::RECIP);
  assign qe_d   = prod_b[44:30];
  // Stage 6: remainder of the estimate.
  assign rem_d = 21'(y5_q - 35'(qe5_q) * 35'(fip_pkg::MOD_K));
  // Stage 7: corrected round value, mix and swap.
  assign f = qe6_q + 15'(rem_q >= 21'(fip_pkg::MOD_K));

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      l_q[0]    <= item_i.left;
      r_q[0]    <= item_i.right;
      mode_q[0] <= item_i.mode;
      x0_q      <= x_d;
    end
    for (int k = 1; k < Stages - 1; k++) begin
      if (en[k]) begin
        l_q[k]    <= l_q[k-1];
        r_q[k]    <= r_q[k-1];
        mode_q[k] <= mode_q[k-1];
      end
    end
    if (en[1]) begin
      x1_q <= x0_q;
      q1_q <= q1_d;
    end
    if (en[2]) begin
      m0_q <= m0_d;
    end
    if (en[3]) begin
      m_q <= m_d;
    end
    if (en[4]) begin
      y4_q <= y_d;
    end
    if (en[5]) begin
      y5_q  <= y4_q;
      qe5_q <= qe_d;
    end
    if (en[6]) begin
      qe6_q <= qe5_q;
      rem_q <= rem_d;
    end
    if (en[7]) begin
      l_q[7]    <= r_q[6];
      r_q[7]    <= l_q[6] ^ {1'b0, f};
      mode_q[7] <= mode_q[6];
    end
  end

  a_mod_estimate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[2] |-> (m0_q < 21'(2 * fip_pkg::MOD_K)))
    else $error("Modulus estimate is off by more than one.");

  a_round_estimate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[6] |-> (rem_q < 21'(2 * fip_pkg::MOD_K)))
    else $error("Rounding quotient estimate is off by more than one.");

  a_narrow_halves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[7] && mode_q[7]) |-> ((l_q[7][15:13] == 3'b000) && (r_q[7][15:13] == 3'b000)))
    else $error("Narrow mode half left its 13-bit range.");

endmodule
